// ===== src/irdg_pkg.sv =====
// ----------------------------------------------------------------------------
// irdg_pkg: shared definitions for the integer to radix digits block
// Widths, radix limits, divider status and the ASCII digit lookup.
// ----------------------------------------------------------------------------
package irdg_pkg;

	localparam int VALUE_BITS = 31;
	localparam int IDX_W      = $clog2(VALUE_BITS);
	localparam int CNT_W      = $clog2(VALUE_BITS + 1);
	localparam int RADIX_W    = 6;
	localparam int DIGIT_W    = 6;
	localparam int CHAR_W     = 7;

	localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;
	localparam logic [DIGIT_W-1:0] DIGIT_MAX = 6'd35;
	localparam logic [DIGIT_W-1:0] DECIMAL_DIGITS = 6'd10;
	localparam logic [CHAR_W-1:0]  CHAR_ZERO = 7'd48;
	localparam logic [CHAR_W-1:0]  CHAR_LETTER_BASE = 7'd55;

	typedef struct packed {
		logic done;
		logic quo_nonzero;
	} div_status_t;

	function automatic logic [CHAR_W-1:0] digit_glyph(input logic [DIGIT_W-1:0] d);
		logic [DIGIT_W-1:0] dc;
		dc = (d > DIGIT_MAX) ? DIGIT_MAX : d;
		if (dc < DECIMAL_DIGITS) begin
			return CHAR_ZERO + {1'b0, dc};
		end else begin
			return CHAR_LETTER_BASE + {1'b0, dc};
		end
	endfunction

endpackage

// ===== src/integer_to_radix_digits.sv =====
// ----------------------------------------------------------------------------
// integer_to_radix_digits: integer to ASCII digits in a radix from 2 to 36
// Converts one value by repeated bit-serial division, then sends its digits.
// ----------------------------------------------------------------------------
//  channel  | signals                      | handshake
//  ---------+------------------------------+-------------------------------
//  input    | value                        | start high while busy is low
//  result   | digit_char, last_digit       | digit_valid for one cycle
//  config   | radix                        | radix_we, no wait
//
// Each digit comes from one pass of the bit-serial divider, then the characters
// are read from the digit buffer, most significant first, through the buffer
// read register and the character register.
// Reset clears the control state and sets the radix to 2.
// The receiver cannot stall; busy falls in the cycle that carries the last
// character.
// ----------------------------------------------------------------------------
module integer_to_radix_digits (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic [irdg_pkg::VALUE_BITS-1:0]    value,
	input  logic                               radix_we,
	input  logic [irdg_pkg::RADIX_W-1:0]       radix,
	output logic                               digit_valid,
	output logic [irdg_pkg::CHAR_W-1:0]        digit_char,
	output logic                               last_digit
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_DIV  = 2'd1;
	localparam logic [1:0] S_EMIT = 2'd2;

	logic [1:0]                       state_q;
	logic [irdg_pkg::RADIX_W-1:0]     radix_q;
	logic [irdg_pkg::RADIX_W-1:0]     eff_radix;
	logic [irdg_pkg::CNT_W-1:0]       n_q;
	logic [irdg_pkg::CNT_W-1:0]       count_q;
	logic [irdg_pkg::IDX_W-1:0]       rd_idx_q;
	logic                             pend_s1;
	logic                             last_s1;
	logic                             strobe_q;
	logic                             last_q;
	logic [irdg_pkg::CHAR_W-1:0]      char_q;

	logic                             accept;
	logic                             div_start;
	logic                             more;
	logic                             rd_en;
	logic [irdg_pkg::VALUE_BITS-1:0]  div_dividend;
	logic [irdg_pkg::VALUE_BITS-1:0]  div_quo;
	logic [irdg_pkg::DIGIT_W-1:0]     div_rem;
	irdg_pkg::div_status_t            div_st;
	logic [irdg_pkg::DIGIT_W-1:0]     rd_data;

	always_comb begin
		if (radix_q < irdg_pkg::RADIX_MIN) begin
			eff_radix = irdg_pkg::RADIX_MIN;
		end else if (radix_q > irdg_pkg::RADIX_MAX) begin
			eff_radix = irdg_pkg::RADIX_MAX;
		end else begin
			eff_radix = radix_q;
		end
	end

	assign accept       = start && !busy;
	assign more         = div_st.quo_nonzero &&
	                      (n_q != irdg_pkg::CNT_W'(irdg_pkg::VALUE_BITS - 1));
	assign div_start    = accept || (state_q == S_DIV && div_st.done && more);
	assign div_dividend = (state_q == S_IDLE) ? value : div_quo;
	assign rd_en        = (state_q == S_EMIT);

	irdg_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dividend),
		.divisor   (eff_radix),
		.quotient  (div_quo),
		.remainder (div_rem),
		.status    (div_st)
	);

	irdg_ram #(
		.WIDTH (irdg_pkg::DIGIT_W),
		.DEPTH (irdg_pkg::VALUE_BITS)
	) u_store (
		.clk   (clk),
		.we    (state_q == S_DIV && div_st.done),
		.waddr (n_q[irdg_pkg::IDX_W-1:0]),
		.wdata (div_rem),
		.re    (rd_en),
		.raddr (rd_idx_q),
		.rdata (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			radix_q  <= irdg_pkg::RADIX_MIN;
			n_q      <= '0;
			count_q  <= '0;
			rd_idx_q <= '0;
			pend_s1  <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			if (radix_we) begin
				radix_q <= radix;
			end
			pend_s1  <= rd_en;
			strobe_q <= pend_s1;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						n_q     <= '0;
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (div_st.done) begin
						n_q <= n_q + 1'b1;
						if (!more) begin
							count_q  <= n_q + 1'b1;
							rd_idx_q <= n_q[irdg_pkg::IDX_W-1:0];
							state_q  <= S_EMIT;
						end
					end
				end
				S_EMIT: begin
					rd_idx_q <= rd_idx_q - 1'b1;
					if (rd_idx_q == '0) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		last_s1 <= (rd_idx_q == '0);
		last_q  <= last_s1;
		char_q  <= irdg_pkg::digit_glyph(rd_data);
	end

	assign busy        = (state_q != S_IDLE) || pend_s1;
	assign digit_valid = strobe_q;
	assign digit_char  = char_q;
	assign last_digit  = last_q;

	a_strobe_follows_read: assert property (@(posedge clk) disable iff (!arst_n)
		digit_valid |-> $past(pend_s1))
		else $error("digit strobe without a preceding buffer read");

	a_accept_sets_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("busy not raised after an accepted item");

	a_read_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT) |-> (irdg_pkg::CNT_W'(rd_idx_q) < count_q))
		else $error("digit buffer read beyond the digit count");

	a_char_legal: assert property (@(posedge clk) disable iff (!arst_n)
		digit_valid |-> ((digit_char >= 7'd48 && digit_char <= 7'd57) ||
		                 (digit_char >= 7'd65 && digit_char <= 7'd90)))
		else $error("digit character outside 0-9 and A-Z");

endmodule

// ===== src/irdg_ram.sv =====
// ----------------------------------------------------------------------------
// irdg_ram: generic single write port RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module irdg_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== src/irdg_div.sv =====
// ----------------------------------------------------------------------------
// irdg_div: bit-serial restoring divider
// Divides the value by the radix one quotient bit per cycle.
// ----------------------------------------------------------------------------
module irdg_div (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic [irdg_pkg::VALUE_BITS-1:0]    dividend,
	input  logic [irdg_pkg::RADIX_W-1:0]       divisor,
	output logic [irdg_pkg::VALUE_BITS-1:0]    quotient,
	output logic [irdg_pkg::DIGIT_W-1:0]       remainder,
	output irdg_pkg::div_status_t              status
);

	logic                             running_q;
	logic                             done_q;
	logic                             nz_q;
	logic [irdg_pkg::IDX_W-1:0]       cnt_q;
	logic [irdg_pkg::VALUE_BITS-1:0]  quo_q;
	logic [irdg_pkg::DIGIT_W-1:0]     rem_q;
	logic [irdg_pkg::DIGIT_W:0]       trial;
	logic                             ge;

	assign trial = {rem_q, quo_q[irdg_pkg::VALUE_BITS-1]};
	assign ge    = trial >= {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= 1'b0;
			done_q    <= 1'b0;
			nz_q      <= 1'b0;
			cnt_q     <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				running_q <= 1'b1;
				nz_q      <= 1'b0;
				cnt_q     <= '0;
			end else if (running_q) begin
				nz_q  <= nz_q | ge;
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == irdg_pkg::IDX_W'(irdg_pkg::VALUE_BITS - 1)) begin
					running_q <= 1'b0;
					done_q    <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (running_q) begin
			quo_q <= {quo_q[irdg_pkg::VALUE_BITS-2:0], ge};
			rem_q <= ge ? irdg_pkg::DIGIT_W'(trial - {1'b0, divisor})
			            : trial[irdg_pkg::DIGIT_W-1:0];
		end
	end

	assign quotient           = quo_q;
	assign remainder          = rem_q;
	assign status.done        = done_q;
	assign status.quo_nonzero = nz_q;

endmodule

// ===== dv/integer_to_radix_digits_test.sv =====
// ----------------------------------------------------------------------------
// integer_to_radix_digits_test: self-checking bench for radix conversion
// Feeds values through a bursty command driver over a sequence of radix
// settings, computes the expected ASCII digits of each accepted value with an
// independent divider, and checks every strobed digit and its last flag.
// ----------------------------------------------------------------------------
module integer_to_radix_digits_test;

	typedef logic [irdg_pkg::VALUE_BITS-1:0] value_t;
	typedef logic [irdg_pkg::RADIX_W-1:0]    radix_t;
	typedef logic [irdg_pkg::CHAR_W-1:0]     char_t;

	typedef struct {
		char_t glyph;
		logic  is_last;
	} digit_expect_t;

	logic                 clk;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	value_t               value;
	logic                 radix_we;
	radix_t               radix;
	logic                 digit_valid;
	char_t                digit_char;
	logic                 last_digit;

	value_t               pending_values[$];
	digit_expect_t        digit_expect_q[$];
	radix_t               model_radix;
	digit_expect_t        oldest_digit;
	bit                   failed;
	bit                   item_taken;
	bit                   took_item;
	bit                   drain_wait;
	int                   burst_left;
	int                   gap_left;
	int                   burst_count;

	integer_to_radix_digits u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.value      (value),
		.radix_we   (radix_we),
		.radix      (radix),
		.digit_valid(digit_valid),
		.digit_char (digit_char),
		.last_digit (last_digit)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void expect_digits(input value_t v);
		radix_t                base;
		value_t                rest;
		int                    rems[$];
		digit_expect_t         e;
		base = model_radix;
		if (base < irdg_pkg::RADIX_MIN) begin
			base = irdg_pkg::RADIX_MIN;
		end else if (base > irdg_pkg::RADIX_MAX) begin
			base = irdg_pkg::RADIX_MAX;
		end
		rest = v;
		do begin
			rems.push_front(int'(rest % base));
			rest = rest / base;
		end while (rest != 0);
		foreach (rems[i]) begin
			e.glyph = (rems[i] < 10) ? char_t'(rems[i] + "0") : char_t'(rems[i] - 10 + "A");
			e.is_last = (i == rems.size() - 1);
			digit_expect_q.push_back(e);
		end
	endfunction

	function automatic value_t random_value();
		case ($urandom_range(0, 5))
			0: return value_t'($urandom_range(0, 40));
			1: return value_t'($urandom);
			default: return value_t'($urandom >> $urandom_range(1, 31));
		endcase
	endfunction

	// Waits until no item is queued or in flight.
	task automatic settle();
		@(negedge clk);
		while (pending_values.size() != 0 || start || busy || digit_expect_q.size() != 0) begin
			@(negedge clk);
		end
		repeat (8) @(negedge clk);
	endtask

	task automatic change_radix(input radix_t r);
		settle();
		radix_we <= 1'b1;
		radix <= r;
		model_radix = r;
		@(negedge clk);
		radix_we <= 1'b0;
	endtask

	// Driver: bursts of items with random gaps, sometimes draining fully.
	always @(negedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			took_item = item_taken;
			item_taken = 1'b0;
			if (took_item) begin
				void'(pending_values.pop_front());
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = $urandom_range(1, 12);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 :
						($urandom_range(0, 7) == 0) ? $urandom_range(1, 1200) :
						$urandom_range(1, 50);
					burst_count++;
					drain_wait = (burst_count % 5 == 1);
				end
			end
			if (took_item || !start) begin
				if (gap_left > 0) begin
					gap_left--;
					start <= 1'b0;
				end else if (drain_wait && (digit_expect_q.size() != 0 || busy)) begin
					start <= 1'b0;
				end else if (pending_values.size() != 0) begin
					drain_wait = 1'b0;
					start <= 1'b1;
					value <= pending_values[0];
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// Monitor: predicts on acceptance and checks each strobed digit.
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				expect_digits(value);
				item_taken = 1'b1;
			end
			if (digit_valid) begin
				if (digit_expect_q.size() == 0) begin
					$error("digit_char: expected none, actual %0d", digit_char);
					failed = 1'b1;
				end else begin
					oldest_digit = digit_expect_q.pop_front();
					if (digit_char !== oldest_digit.glyph) begin
						$error("digit_char: expected %0d, actual %0d",
							oldest_digit.glyph, digit_char);
						failed = 1'b1;
					end
					if (last_digit !== oldest_digit.is_last) begin
						$error("last_digit: expected %0d, actual %0d",
							oldest_digit.is_last, last_digit);
						failed = 1'b1;
					end
				end
			end
		end
	end

	initial begin
		#30000000;
		$display("status: fail");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		value = '0;
		radix_we = 1'b0;
		radix = '0;
		model_radix = irdg_pkg::RADIX_MIN;
		failed = 1'b0;
		item_taken = 1'b0;
		drain_wait = 1'b0;
		burst_left = 4;
		gap_left = 0;
		burst_count = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		pending_values.push_back(value_t'(0));
		pending_values.push_back(value_t'(1));
		pending_values.push_back(value_t'(2));
		pending_values.push_back('1);
		change_radix(radix_t'(10));
		pending_values.push_back(value_t'(9));
		pending_values.push_back(value_t'(10));
		pending_values.push_back(value_t'(999999999));
		pending_values.push_back(value_t'(1000000000));
		change_radix(radix_t'(16));
		pending_values.push_back(value_t'(15));
		pending_values.push_back(value_t'(16));
		pending_values.push_back('1);
		change_radix(irdg_pkg::RADIX_MAX);
		pending_values.push_back(value_t'(35));
		pending_values.push_back(value_t'(36));
		pending_values.push_back(value_t'(1295));
		pending_values.push_back('1);
		change_radix(radix_t'(0));
		pending_values.push_back(value_t'(0));
		pending_values.push_back(value_t'(3));
		change_radix(radix_t'(1));
		pending_values.push_back('1);
		change_radix(radix_t'(37));
		pending_values.push_back(value_t'(35));
		pending_values.push_back(value_t'(36));
		change_radix('1);
		pending_values.push_back(value_t'(0));
		pending_values.push_back('1);

		for (int phase = 0; phase < 12; phase++) begin
			if (phase == 0) begin
				change_radix(irdg_pkg::RADIX_MIN);
			end else if (phase == 11) begin
				change_radix(irdg_pkg::RADIX_MAX);
			end else if ($urandom_range(0, 5) == 0) begin
				change_radix(radix_t'($urandom_range(0, 63)));
			end else begin
				change_radix(radix_t'($urandom_range(2, 36)));
			end
			repeat (30) pending_values.push_back(random_value());
		end

		settle();
		repeat (40) @(posedge clk);
		if (!failed) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
